### hdl/sdrepl_pkg.sv
// Shared types and constants of the set-dueling SRRIP/MRU replacement engine.
// No dependencies; sdrepl_row_update and the top level import this package.
`default_nettype none

package sdrepl_pkg;

    localparam int RANK_W = 4;
    localparam int VMASK_W = 16;

    localparam logic [RANK_W-1:0] RRPV_MAX = 4'd3;
    localparam logic [RANK_W-1:0] RRPV_LONG = 4'd2;
    localparam logic [RANK_W-1:0] RANK_TOP = 4'd15;
    localparam logic [RANK_W-1:0] RANK_ZERO = 4'd0;

    localparam logic [1:0] FUNC_QUERY = 2'd0;
    localparam logic [1:0] FUNC_FILL = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;

    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_RFO = 3'd1;
    localparam logic [2:0] KIND_WRITEBACK = 3'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC
    } t_state;

    typedef enum logic [1:0] {
        ROLE_SRRIP,
        ROLE_MRU,
        ROLE_FOLLOW
    } t_role;

    // Request decoded for the row update logic.
    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         kind;
        logic               hit;
        logic [VMASK_W-1:0] valid_mask;
        logic               use_mru;
        logic               set_ok;
        logic               way_ok;
    } t_upd_cmd;

endpackage

`default_nettype wire

### hdl/sdrepl_ifs.sv
// Valid/ready channel interfaces of the replacement engine: request and response.
// Depends on nothing; the top level uses one instance of each.
`default_nettype none

interface sdrepl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [2:0]  access_kind;
    logic [15:0] valid_mask;
    logic        was_hit;

    modport source (
        output valid, func, set_index, way_index, access_kind, valid_mask, was_hit,
        input  ready
    );
    modport sink (
        input  valid, func, set_index, way_index, access_kind, valid_mask, was_hit,
        output ready
    );
endinterface

interface sdrepl_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] victim_way;
    logic       followers_mru;

    modport source (output valid, victim_way, followers_mru, input ready);
    modport sink (input valid, victim_way, followers_mru, output ready);
endinterface

`default_nettype wire

### hdl/sdrepl_rank_mem.sv
// Rank memory: one row of per-way ranks for each set, one write and one read port.
// Read data is registered. No package dependencies.
`default_nettype none

module sdrepl_rank_mem #(
    parameter int DEPTH = 2048,
    parameter int ROW_W = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [ROW_W-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [ROW_W-1:0]  o_rd_data
);

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [ROW_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/sdrepl_row_update.sv
// Victim selection and rank update for one set row (SRRIP aging, MRU touch).
// Depends on sdrepl_pkg for rank constants, codes and the command struct.
`default_nettype none

module sdrepl_row_update import sdrepl_pkg::*; #(
    parameter int WAY_COUNT = 16
) (
    input  logic [WAY_COUNT*RANK_W-1:0]    i_row,
    input  logic [$clog2(WAY_COUNT)-1:0]   i_way,
    input  t_upd_cmd                       i_cmd,
    output logic [WAY_COUNT*RANK_W-1:0]    o_row,
    output logic                           o_wr_en,
    output logic [$clog2(WAY_COUNT)-1:0]   o_victim
);

    localparam int WB = $clog2(WAY_COUNT);

    // Lowest set bit of a mask, found by isolating it and or-ing the indices.
    function automatic logic [WB-1:0] f_first(input logic [WAY_COUNT-1:0] m);
        logic [WAY_COUNT-1:0] oh;
        logic [WB-1:0]        idx;
        oh = m & (~m + 1'b1);
        idx = '0;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (oh[w]) begin
                idx = idx | WB'(w);
            end
        end
        return idx;
    endfunction

    logic [RANK_W-1:0]    v_rk [WAY_COUNT];
    logic [RANK_W-1:0]    v_aged [WAY_COUNT];
    logic [RANK_W-1:0]    v_touch [WAY_COUNT];
    logic [RANK_W-1:0]    v_new [WAY_COUNT];
    logic [WAY_COUNT-1:0] v_inv;
    logic [WAY_COUNT-1:0] v_eq3;
    logic [WAY_COUNT-1:0] v_lt3;
    logic [WAY_COUNT-1:0] v_eq2;
    logic [WAY_COUNT-1:0] v_eq1;
    logic [WAY_COUNT-1:0] v_reach;
    logic [WAY_COUNT-1:0] v_is_min;
    logic [RANK_W-1:0]    v_best;
    logic [RANK_W-1:0]    v_age;
    logic [RANK_W-1:0]    v_fill_rank;
    logic [WB-1:0]        v_srrip_vic;
    logic                 v_aging;
    logic                 v_mru_touch;

    always_comb begin
        for (int w = 0; w < WAY_COUNT; w++) begin
            v_rk[w] = i_row[w*RANK_W +: RANK_W];
            v_inv[w] = (w < VMASK_W) ? !i_cmd.valid_mask[w[3:0]] : 1'b0;
            v_eq3[w] = (v_rk[w] == RRPV_MAX);
            v_lt3[w] = (v_rk[w] < RRPV_MAX);
            v_eq2[w] = (v_rk[w] == RRPV_LONG);
            v_eq1[w] = (v_rk[w] == RRPV_LONG - 4'd1);
        end

        // Among ranks below the maximum only 0, 1 and 2 exist.
        if (|v_eq2) begin
            v_best = RRPV_LONG;
        end else if (|v_eq1) begin
            v_best = RRPV_LONG - 4'd1;
        end else begin
            v_best = RANK_ZERO;
        end
        v_age = RRPV_MAX - v_best;

        for (int w = 0; w < WAY_COUNT; w++) begin
            v_reach[w] = v_lt3[w] && (v_rk[w] == v_best);
            v_aged[w] = v_lt3[w] ? v_rk[w] + v_age : v_rk[w];
            v_touch[w] = (v_rk[w] < RANK_TOP) ? v_rk[w] + 4'd1 : v_rk[w];
            if (WB'(w) == i_way) begin
                v_touch[w] = RANK_ZERO;
            end
        end

        // A way is the MRU victim when it is strictly below every lower way
        // and not above any higher way.
        for (int w = 0; w < WAY_COUNT; w++) begin
            v_is_min[w] = 1'b1;
            for (int j = 0; j < WAY_COUNT; j++) begin
                if (j < w && !(v_rk[w] < v_rk[j])) begin
                    v_is_min[w] = 1'b0;
                end
                if (j > w && !(v_rk[w] <= v_rk[j])) begin
                    v_is_min[w] = 1'b0;
                end
            end
        end

        v_aging = !(|v_eq3) && (|v_lt3);
        if (|v_eq3) begin
            v_srrip_vic = f_first(v_eq3);
        end else if (|v_lt3) begin
            v_srrip_vic = f_first(v_reach);
        end else begin
            v_srrip_vic = '0;
        end

        v_mru_touch = (i_cmd.kind == KIND_LOAD) || (i_cmd.kind == KIND_RFO);
        v_fill_rank = (i_cmd.kind == KIND_WRITEBACK) ? RRPV_MAX : RRPV_LONG;

        for (int w = 0; w < WAY_COUNT; w++) begin
            v_new[w] = v_rk[w];
        end
        o_wr_en = 1'b0;
        o_victim = '0;

        case (i_cmd.func)
            FUNC_QUERY: begin
                if (|v_inv) begin
                    o_victim = f_first(v_inv);
                end else if (i_cmd.set_ok) begin
                    if (i_cmd.use_mru) begin
                        o_victim = f_first(v_is_min);
                    end else begin
                        o_victim = v_srrip_vic;
                        if (v_aging) begin
                            o_wr_en = 1'b1;
                            for (int w = 0; w < WAY_COUNT; w++) begin
                                v_new[w] = v_aged[w];
                            end
                        end
                    end
                end
            end
            FUNC_FILL: begin
                if (i_cmd.set_ok && i_cmd.way_ok) begin
                    o_wr_en = 1'b1;
                    for (int w = 0; w < WAY_COUNT; w++) begin
                        if (i_cmd.use_mru && v_mru_touch) begin
                            v_new[w] = v_touch[w];
                        end else if (WB'(w) == i_way) begin
                            v_new[w] = i_cmd.use_mru ? RANK_ZERO : v_fill_rank;
                        end
                    end
                end
            end
            FUNC_UPDATE: begin
                if (i_cmd.set_ok && i_cmd.way_ok && i_cmd.hit
                        && (i_cmd.kind != KIND_WRITEBACK)) begin
                    o_wr_en = 1'b1;
                    for (int w = 0; w < WAY_COUNT; w++) begin
                        if (i_cmd.use_mru) begin
                            v_new[w] = v_touch[w];
                        end else if (WB'(w) == i_way) begin
                            v_new[w] = RANK_ZERO;
                        end
                    end
                end
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase

        for (int w = 0; w < WAY_COUNT; w++) begin
            o_row[w*RANK_W +: RANK_W] = v_new[w];
        end
    end

endmodule

`default_nettype wire

### hdl/set_dueling_srrip_mru_replacement.sv
// Top level of the set-dueling SRRIP/MRU replacement engine: sequencer, duel
// counter, response register. Uses sdrepl_pkg, sdrepl_ifs, sdrepl_rank_mem and
// sdrepl_row_update.
//
//   channel  | direction | beat carries
//   ---------+-----------+-------------------------------------------------
//   i_req    | in        | func, set_index, way_index, access_kind, valid_mask, was_hit
//   o_rsp    | out       | victim_way, followers_mru
//
// After acceptance a request passes through READ, which issues the row read, and
// CALC, which updates the registered row, writes it back and loads the response
// register, before returning to IDLE with i_req.ready high; no new request is taken
// before then. The response beat is valid once CALC completes. The single rank
// memory port pair sets this sequence. After reset a clearing pass writes every
// row to rank 3 with i_req.ready low. The update waits while the response register
// still holds a beat that o_rsp has not taken.
`default_nettype none

module set_dueling_srrip_mru_replacement import sdrepl_pkg::*; #(
    parameter int SET_COUNT = 2048,
    parameter int WAY_COUNT = 16,
    parameter int LEADERS_PER_RULE = 32,
    parameter int COUNTER_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdrepl_req_if.sink    i_req,
    sdrepl_rsp_if.source  o_rsp
);

    localparam int WB = $clog2(WAY_COUNT);
    localparam int ROW_W = WAY_COUNT * RANK_W;
    localparam int ADDR_W = $clog2(SET_COUNT);
    localparam int REGION = SET_COUNT / LEADERS_PER_RULE;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_MID = COUNTER_BITS'(1) << (COUNTER_BITS - 1);

    t_state r_state, n_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [1:0]              r_func;
    logic [10:0]             r_set;
    logic [3:0]              r_way;
    logic [2:0]              r_kind;
    logic [VMASK_W-1:0]      r_vmask;
    logic                    r_hit;
    logic [COUNTER_BITS-1:0] r_cnt, n_cnt;
    logic                    r_out_valid;
    logic [3:0]              r_victim;
    logic                    r_fmru;

    logic             v_accept;
    logic             v_advance;
    logic             v_clear_last;
    logic             v_set_ok;
    logic             v_way_ok;
    t_role            v_role;
    logic             v_use_mru;
    t_upd_cmd         v_cmd;
    logic             v_mem_wr;
    logic [ADDR_W-1:0] v_mem_waddr;
    logic [ROW_W-1:0] v_mem_wdata;
    logic             v_mem_rd;
    logic [ROW_W-1:0] v_rd_row;
    logic [ROW_W-1:0] v_upd_row;
    logic             v_upd_wr;
    logic [WB-1:0]    v_upd_victim;

    assign v_set_ok = 32'(r_set) < 32'(SET_COUNT);
    assign v_way_ok = 32'(r_way) < 32'(WAY_COUNT);
    assign v_clear_last = (r_clr_addr == ADDR_W'(SET_COUNT - 1));
    assign v_accept = i_req.valid && i_req.ready;

    // Leader sets: the first and the middle set of each region.
    always_comb begin
        v_role = ROLE_FOLLOW;
        for (int k = 0; k < LEADERS_PER_RULE; k++) begin
            if (32'(r_set) == 32'(k * REGION)) begin
                v_role = ROLE_SRRIP;
            end
            if (32'(r_set) == 32'(k * REGION + REGION / 2)) begin
                v_role = ROLE_MRU;
            end
        end
    end

    // Counter value after this request; a fill in a leader set moves it.
    always_comb begin
        n_cnt = r_cnt;
        if ((r_func == FUNC_FILL) && v_set_ok && v_way_ok) begin
            if ((v_role == ROLE_SRRIP) && (r_cnt != CNT_MAX)) begin
                n_cnt = r_cnt + 1'b1;
            end else if ((v_role == ROLE_MRU) && (r_cnt != '0)) begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_comb begin
        case (v_role)
            ROLE_SRRIP: v_use_mru = 1'b0;
            ROLE_MRU:   v_use_mru = 1'b1;
            default:    v_use_mru = (n_cnt >= CNT_MID);
        endcase
    end

    always_comb begin
        v_cmd.func = r_func;
        v_cmd.kind = r_kind;
        v_cmd.hit = r_hit;
        v_cmd.valid_mask = r_vmask;
        v_cmd.use_mru = v_use_mru;
        v_cmd.set_ok = v_set_ok;
        v_cmd.way_ok = v_way_ok;
    end

    sdrepl_row_update #(
        .WAY_COUNT (WAY_COUNT)
    ) u_row_update (
        .i_row    (v_rd_row),
        .i_way    (WB'(r_way)),
        .i_cmd    (v_cmd),
        .o_row    (v_upd_row),
        .o_wr_en  (v_upd_wr),
        .o_victim (v_upd_victim)
    );

    sdrepl_rank_mem #(
        .DEPTH  (SET_COUNT),
        .ROW_W  (ROW_W),
        .ADDR_W (ADDR_W)
    ) u_rank_mem (
        .i_clk     (i_clk),
        .i_wr_en   (v_mem_wr),
        .i_wr_addr (v_mem_waddr),
        .i_wr_data (v_mem_wdata),
        .i_rd_en   (v_mem_rd),
        .i_rd_addr (ADDR_W'(r_set)),
        .o_rd_data (v_rd_row)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (v_clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (v_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        i_req.ready = 1'b0;
        v_mem_rd = 1'b0;
        v_advance = 1'b0;
        v_mem_wr = 1'b0;
        v_mem_waddr = ADDR_W'(r_set);
        v_mem_wdata = v_upd_row;
        case (r_state)
            ST_CLEAR: begin
                v_mem_wr = 1'b1;
                v_mem_waddr = r_clr_addr;
                v_mem_wdata = {WAY_COUNT{RRPV_MAX}};
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_READ: begin
                v_mem_rd = 1'b1;
            end
            ST_CALC: begin
                v_advance = !r_out_valid || o_rsp.ready;
                v_mem_wr = v_advance && v_upd_wr;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr_addr <= '0;
            r_cnt <= CNT_MID;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (v_advance) begin
                r_cnt <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_func <= i_req.func;
            r_set <= i_req.set_index;
            r_way <= i_req.way_index;
            r_kind <= i_req.access_kind;
            r_vmask <= i_req.valid_mask;
            r_hit <= i_req.was_hit;
        end
        if (v_advance) begin
            r_victim <= 4'(v_upd_victim);
            r_fmru <= (n_cnt >= CNT_MID);
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.victim_way = r_victim;
    assign o_rsp.followers_mru = r_fmru;

endmodule

`default_nettype wire
